// File: rtl/core/gcl_pkg.sv
// Shared types and constants for the gcd and lcm unit.
`default_nettype none

package gcl_pkg;

   // Field widths of the channels.
   localparam int DATA_WIDTH    = 32;
   localparam int RESULT_WIDTH  = 64;

   // Operand bits actually used (8 to 32); higher bits are ignored.
   localparam int OPERAND_WIDTH = 32;
   localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
   localparam int COUNT_WIDTH   = $clog2(OPERAND_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GCD_DIV,
      ST_LCM_DIV,
      ST_MULT,
      ST_FINISH
   } gcl_state_type;

   typedef enum logic {
      DIV_SEL_GCD,
      DIV_SEL_LCM
   } gcl_div_sel_type;

   typedef struct packed {
      logic            load;
      logic            div_start;
      gcl_div_sel_type div_sel;
      logic            div_step;
      logic            gcd_update;
      logic            mult;
      logic            load_result;
   } gcl_cmd_type;

   typedef struct packed {
      logic x_zero;
      logic any_zero;
      logic div_done;
   } gcl_status_type;

endpackage

`default_nettype wire

// File: rtl/core/gcl_if.sv
// Handshake channel interfaces for operand requests and results.
`default_nettype none

interface gcl_req_if;
   import gcl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] first_operand;
   logic [DATA_WIDTH-1:0] second_operand;

   modport source (output valid, output first_operand, output second_operand, input ready);
   modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface gcl_rsp_if;
   import gcl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   divisor_result;
   logic [RESULT_WIDTH-1:0] multiple_result;
   logic                    both_zero;

   modport source (output valid, output divisor_result, output multiple_result,
                   output both_zero, input ready);
   modport sink   (input valid, input divisor_result, input multiple_result,
                   input both_zero, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gcl_datapath.sv
// Datapath: operand registers, shared restoring divider, multiplier, result register.
`default_nettype none

module gcl_datapath (
   input  wire logic                            clock,
   input  wire gcl_pkg::gcl_cmd_type            cmd,
   output gcl_pkg::gcl_status_type              status,
   input  wire logic [gcl_pkg::DATA_WIDTH-1:0]  first_operand,
   input  wire logic [gcl_pkg::DATA_WIDTH-1:0]  second_operand,
   output logic [gcl_pkg::DATA_WIDTH-1:0]       divisor_result,
   output logic [gcl_pkg::RESULT_WIDTH-1:0]     multiple_result,
   output logic                                 both_zero
);
   import gcl_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]             a_ff, a_in;
   logic [W-1:0]             b_ff, b_in;
   logic [W-1:0]             x_ff, x_in;
   logic [W-1:0]             y_ff, y_in;
   logic [W-1:0]             rem_ff, rem_in;
   logic [W-1:0]             quo_ff, quo_in;
   logic [W-1:0]             dvs_ff, dvs_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [RESULT_WIDTH-1:0]  product_ff, product_in;
   logic [DATA_WIDTH-1:0]    gcd_out_ff, gcd_out_in;
   logic [RESULT_WIDTH-1:0]  lcm_out_ff, lcm_out_in;
   logic                     flag_out_ff, flag_out_in;

   logic [W:0]               shifted;
   logic [W:0]               diff;
   logic [PRODUCT_WIDTH-1:0] prod_w;
   logic                     a_zero;
   logic                     b_zero;

   assign a_zero = (a_ff == '0);
   assign b_zero = (b_ff == '0);

   // One restoring step: shift the next dividend bit in, subtract if it fits.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign prod_w  = quo_ff * b_ff;

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      count_in    = count_ff;
      product_in  = product_ff;
      gcd_out_in  = gcd_out_ff;
      lcm_out_in  = lcm_out_ff;
      flag_out_in = flag_out_ff;

      if (cmd.load) begin
         a_in = first_operand[W-1:0];
         b_in = second_operand[W-1:0];
         x_in = first_operand[W-1:0];
         y_in = second_operand[W-1:0];
      end

      if (cmd.div_start) begin
         rem_in   = '0;
         count_in = '0;
         if (cmd.div_sel == DIV_SEL_GCD) begin
            quo_in = y_ff;
            dvs_in = x_ff;
         end else begin
            quo_in = a_ff;
            dvs_in = y_ff;
         end
      end

      if (cmd.div_step) begin
         count_in = count_ff + COUNT_WIDTH'(1);
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end

      // Euclid: y takes x, x takes the remainder.
      if (cmd.gcd_update) begin
         y_in = x_ff;
         x_in = rem_ff;
      end

      if (cmd.mult) begin
         product_in = RESULT_WIDTH'(prod_w);
      end

      if (cmd.load_result) begin
         gcd_out_in  = DATA_WIDTH'(y_ff);
         lcm_out_in  = (a_zero || b_zero) ? '0 : product_ff;
         flag_out_in = a_zero && b_zero;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      count_ff    <= count_in;
      product_ff  <= product_in;
      gcd_out_ff  <= gcd_out_in;
      lcm_out_ff  <= lcm_out_in;
      flag_out_ff <= flag_out_in;
   end

   assign status.x_zero   = (x_ff == '0);
   assign status.any_zero = a_zero || b_zero;
   assign status.div_done = (count_ff == COUNT_WIDTH'(W));

   assign divisor_result  = gcd_out_ff;
   assign multiple_result = lcm_out_ff;
   assign both_zero       = flag_out_ff;

endmodule

`default_nettype wire

// File: rtl/core/gcl_ctrl.sv
// Controller state machine sequencing the Euclid loop, the lcm division and the result.
`default_nettype none

module gcl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire gcl_pkg::gcl_status_type status,
   output gcl_pkg::gcl_cmd_type         cmd
);
   import gcl_pkg::*;

   gcl_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.x_zero)       state_in = ST_GCD_DIV;
            else if (status.any_zero) state_in = ST_FINISH;
            else                      state_in = ST_LCM_DIV;
         end
         ST_GCD_DIV: begin
            if (status.div_done) state_in = ST_CHECK;
         end
         ST_LCM_DIV: begin
            if (status.div_done) state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            // Start the next remainder, or, when the loop is over and neither operand is zero, the quotient a / gcd.
            if (!status.x_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_GCD;
            end else if (!status.any_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_LCM;
            end
         end
         ST_GCD_DIV: begin
            if (status.div_done) cmd.gcd_update = 1'b1;
            else                 cmd.div_step   = 1'b1;
         end
         ST_LCM_DIV: begin
            cmd.div_step = !status.div_done;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_result = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_result)   out_valid_in = 1'b1;
      else if (rsp_ready)    out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/gcd_lcm_unit.sv
// Top level of the gcd and lcm unit: controller, datapath and channel wiring.
// Flow: the operands are loaded, the Euclid remainders are computed one by one on the divider,
// then a / gcd is divided out and multiplied by b, and the result is registered.
// Throughput: one transaction at a time; a new request is taken once the previous result
// has been written to the output register, where it may still wait for the receiver.
// Reset (synchronous, active high) returns the controller to idle and drops the result.
`default_nettype none

module gcd_lcm_unit (
   input  wire logic clock,
   input  wire logic reset,
   gcl_req_if.sink   req_ch,
   gcl_rsp_if.source rsp_ch
);
   import gcl_pkg::*;

   gcl_cmd_type    cmd;
   gcl_status_type status;

   gcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gcl_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .first_operand   (req_ch.first_operand),
      .second_operand  (req_ch.second_operand),
      .divisor_result  (rsp_ch.divisor_result),
      .multiple_result (rsp_ch.multiple_result),
      .both_zero       (rsp_ch.both_zero)
   );

endmodule

`default_nettype wire

// File: rtl/core/gcl_checker.sv
// Port-level checks for the gcd and lcm unit and their binding to the top level.
`default_nettype none

module gcl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [gcl_pkg::DATA_WIDTH-1:0]    divisor_result,
   input wire logic [gcl_pkg::RESULT_WIDTH-1:0]  multiple_result,
   input wire logic                              both_zero
);
   import gcl_pkg::*;

   // A result never survives reset.
   a_reset_drops_result: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One transaction in flight: no new request right after one is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // Both operands zero leaves nothing but zeros in the fields.
   a_both_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && both_zero) |-> (divisor_result == '0 && multiple_result == '0))
      else $error("both-zero result carries nonzero fields");

   // A nonzero lcm comes only with a nonzero gcd.
   a_lcm_needs_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && multiple_result != '0) |-> (divisor_result != '0 && !both_zero))
      else $error("nonzero lcm with zero gcd");

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(divisor_result) && $stable(multiple_result)
          && $stable(both_zero)))
      else $error("stalled result changed");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .divisor_result  (rsp_ch.divisor_result),
   .multiple_result (rsp_ch.multiple_result),
   .both_zero       (rsp_ch.both_zero)
);

`default_nettype wire
